FILE: rtl/frequent_items_sketch_defines.svh
// ---------------------------------------------------------------------------
// frequent_items_sketch_defines
// Assertion helpers shared by the frequent items sketch RTL.
// ---------------------------------------------------------------------------
`ifndef FREQUENT_ITEMS_SKETCH_DEFINES_SVH
`define FREQUENT_ITEMS_SKETCH_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define FIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same, but also checked during reset.
`define FIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/fis_pkg.sv
// ---------------------------------------------------------------------------
// fis_pkg
// Types, constants and helpers for the frequent items sketch.
// ---------------------------------------------------------------------------
package fis_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_W         = 32;
    localparam int CNT_W         = 32;
    localparam int RANK_W        = 5;
    localparam int PASS_W        = $clog2(TABLE_ENTRIES + 1);

    localparam logic [KEY_W-1:0] SENTINEL_KEY = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_GET = 1'b1;

    typedef struct packed {
        logic              action;
        logic signed [KEY_W-1:0] item_key;
        logic [RANK_W-1:0] rank;
    } fis_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] ranked_key;
        logic              found;
    } fis_out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] floor_val;
    } fis_entry_t;

    // per-cell command from the controller
    typedef struct packed {
        logic inc;
        logic take;
        logic sort_en;
        logic pair_left;
        logic pair_right;
    } fis_cell_ctrl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] weight_of(input fis_entry_t e);
        return e.count - e.floor_val;
    endfunction

endpackage

FILE: rtl/fis_cell.sv
// ---------------------------------------------------------------------------
// fis_cell
// One table entry: counts, takes over, and swaps with a neighbour in a sort.
// ---------------------------------------------------------------------------
module fis_cell import fis_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  fis_cell_ctrl_t   ctrl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [CNT_W-1:0] gfloor,
    input  fis_entry_t       left_entry,
    input  fis_entry_t       right_entry,
    output fis_entry_t       entry,
    output logic             match,
    output logic             is_free
);

    fis_entry_t entry_reg, entry_next;
    logic [CNT_W-1:0] w_self;

    assign w_self  = weight_of(entry_reg);
    assign entry   = entry_reg;
    assign match   = (entry_reg.key == new_key);
    assign is_free = (entry_reg.count == gfloor);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.take) begin
            entry_next.key       = new_key;
            entry_next.count     = sat_inc(entry_reg.count);
            entry_next.floor_val = gfloor;
        end else if (ctrl.inc) begin
            entry_next.count = sat_inc(entry_reg.count);
        end else if (ctrl.sort_en) begin
            // strict compare keeps equal weights in order
            if (ctrl.pair_left && (w_self < weight_of(right_entry))) begin
                entry_next = right_entry;
            end else if (ctrl.pair_right && (weight_of(left_entry) < w_self)) begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.key       <= SENTINEL_KEY;
            entry_reg.count     <= '0;
            entry_reg.floor_val <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: rtl/frequent_items_sketch.sv
// ---------------------------------------------------------------------------
// frequent_items_sketch
// Heavy-hitter table built as a chain of cells with an in-place stable sort.
// ---------------------------------------------------------------------------
//  channel | dir | ports                     | item
//  input   | in  | s_valid s_ready s_data    | add key / get rank
//  result  | out | m_valid m_ready m_data    | key at rank, found
//
//  An add is applied in place: all cells compare the key at once.
//  A get on a sorted table answers from a registered result; on an unsorted
//  one it first runs TABLE_ENTRIES odd-even transposition passes along the chain.
//  Reset clears all cells, the global floor and marks the table sorted.
//  A waiting result does not stop adds; a get waits until the result slot
//  can be freed.
// ---------------------------------------------------------------------------
`include "frequent_items_sketch_defines.svh"

module frequent_items_sketch import fis_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fis_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fis_out_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              phase_reg, phase_next;
    logic              sorted_reg, sorted_next;
    logic [CNT_W-1:0]  gfloor_reg, gfloor_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              m_valid_reg, m_valid_next;
    fis_out_t          m_data_reg, m_data_next;

    fis_entry_t     cells [TABLE_ENTRIES];
    fis_cell_ctrl_t ctrl  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match_vec, free_vec, inc_vec, take_vec;
    logic any_match, any_free, accept, slot_free;
    logic [RANK_W-1:0] rank_sel;
    logic [KEY_W-1:0]  key_at_rank;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) &&
                       (slot_free || (s_data.action == ACT_ADD));
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // highest matching cell wins; lowest free cell is taken over
    always_comb begin
        inc_vec  = '0;
        take_vec = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (match_vec[i]) begin
                inc_vec    = '0;
                inc_vec[i] = 1'b1;
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                take_vec    = '0;
                take_vec[i] = 1'b1;
            end
        end
    end
    assign any_match = |match_vec;
    assign any_free  = |free_vec;

    // chain of cells; ends see themselves as neighbour
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic is_add;
        assign is_add = accept && (s_data.action == ACT_ADD);
        assign ctrl[g].inc        = is_add && inc_vec[g];
        assign ctrl[g].take       = is_add && !any_match && take_vec[g];
        assign ctrl[g].sort_en    = (state_reg == ST_SORT);
        assign ctrl[g].pair_left  = ((g % 2) == int'(phase_reg)) &&
                                    (g + 1 < TABLE_ENTRIES);
        assign ctrl[g].pair_right = (g >= 1) && (((g + 1) % 2) == int'(phase_reg));

        fis_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl[g]),
            .new_key     (s_data.item_key),
            .gfloor      (gfloor_reg),
            .left_entry  (cells[(g > 0) ? g - 1 : g]),
            .right_entry (cells[(g + 1 < TABLE_ENTRIES) ? g + 1 : g]),
            .entry       (cells[g]),
            .match       (match_vec[g]),
            .is_free     (free_vec[g])
        );
    end

    assign rank_sel = (state_reg == ST_RESP) ? rank_reg : s_data.rank;

    always_comb begin
        key_at_rank = SENTINEL_KEY;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (32'(rank_sel) == i) key_at_rank = cells[i].key;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        phase_next   = phase_reg;
        sorted_next  = sorted_reg;
        gfloor_next  = gfloor_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.action == ACT_ADD) begin
                        if (any_match)      sorted_next = 1'b0;
                        else if (!any_free) gfloor_next = sat_inc(gfloor_reg);
                    end else if (sorted_reg) begin
                        m_valid_next           = 1'b1;
                        m_data_next.found      = 32'(s_data.rank) < TABLE_ENTRIES;
                        m_data_next.ranked_key = key_at_rank;
                    end else begin
                        rank_next  = s_data.rank;
                        pass_next  = '0;
                        phase_next = 1'b0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                phase_next = !phase_reg;
                pass_next  = pass_reg + 1'b1;
                if (32'(pass_reg) == TABLE_ENTRIES - 1) state_next = ST_RESP;
            end
            ST_RESP: begin
                sorted_next            = 1'b1;
                m_valid_next           = 1'b1;
                m_data_next.found      = 32'(rank_reg) < TABLE_ENTRIES;
                m_data_next.ranked_key = key_at_rank;
                state_next             = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            phase_reg   <= 1'b0;
            sorted_reg  <= 1'b1;
            gfloor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            phase_reg   <= phase_next;
            sorted_reg  <= sorted_next;
            gfloor_reg  <= gfloor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rank_reg   <= rank_next;
        m_data_reg <= m_data_next;
    end

    `FIS_ASSERT(a_busy_no_ready, (state_reg != ST_IDLE) |-> !s_ready, "ready while busy")
    `FIS_ASSERT(a_sel_onehot, $onehot0(inc_vec) && $onehot0(take_vec), "multiple cells selected")
    `FIS_ASSERT(a_rose_from_get, $rose(m_valid_reg) |-> $past(state_reg == ST_RESP || (accept && s_data.action == ACT_GET)), "result without get")
    `FIS_ASSERT(a_resp_slot, (state_reg == ST_RESP) |-> !m_valid_reg, "result slot busy at sort end")

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the frequent items sketch: a directed table of
// items, then random add/get traffic, all scored against a behavioural table.
// ---------------------------------------------------------------------------
module testbench import fis_pkg::*;;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fis_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fis_out_t m_data;

    frequent_items_sketch i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Behavioural copy of the table
    logic [KEY_W-1:0] tbl_key   [TABLE_ENTRIES];
    logic [CNT_W-1:0] tbl_count [TABLE_ENTRIES];
    logic [CNT_W-1:0] tbl_floor [TABLE_ENTRIES];
    logic [CNT_W-1:0] floor_lvl;
    bit               tbl_sorted;

    fis_out_t answers_due[$];
    int       errors = 0;
    bit       calm = 1'b0;   // no idling on either side while set

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1;
    endfunction

    task automatic table_clear();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_key[i] = SENTINEL_KEY;
            tbl_count[i] = '0;
            tbl_floor[i] = '0;
        end
        floor_lvl = '0;
        tbl_sorted = 1'b1;
    endtask

    // Stable insertion sort by count minus floor, heaviest first
    task automatic table_rank_order();
        logic [KEY_W-1:0] k;
        logic [CNT_W-1:0] c, f, w;
        int j;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
            k = tbl_key[i]; c = tbl_count[i]; f = tbl_floor[i]; w = c - f;
            j = i;
            while (j > 0 && (tbl_count[j-1] - tbl_floor[j-1]) < w) begin
                tbl_key[j] = tbl_key[j-1];
                tbl_count[j] = tbl_count[j-1];
                tbl_floor[j] = tbl_floor[j-1];
                j--;
            end
            tbl_key[j] = k; tbl_count[j] = c; tbl_floor[j] = f;
        end
    endtask

    // Apply one item to the table; a get queues its answer
    task automatic table_apply(input fis_in_t it);
        bit hit;
        bit have_free;
        int free_idx;
        fis_out_t r;
        hit = 1'b0; have_free = 1'b0; free_idx = 0;
        if (it.action == ACT_ADD) begin
            // highest matching cell wins; lowest cell at the floor is taken
            for (int c = TABLE_ENTRIES - 1; c >= 0 && !hit; c--) begin
                if (tbl_key[c] == it.item_key) begin
                    tbl_count[c] = bump(tbl_count[c]);
                    tbl_sorted = 1'b0;
                    hit = 1'b1;
                end else if (tbl_count[c] == floor_lvl) begin
                    have_free = 1'b1;
                    free_idx = c;
                end
            end
            if (!hit) begin
                if (have_free) begin
                    tbl_key[free_idx] = it.item_key;
                    tbl_count[free_idx] = bump(tbl_count[free_idx]);
                    tbl_floor[free_idx] = floor_lvl;
                end else begin
                    floor_lvl = bump(floor_lvl);
                end
            end
        end else begin
            if (!tbl_sorted) begin
                table_rank_order();
                tbl_sorted = 1'b1;
            end
            if (it.rank < TABLE_ENTRIES) begin
                r.ranked_key = tbl_key[it.rank];
                r.found = 1'b1;
            end else begin
                r.ranked_key = SENTINEL_KEY;
                r.found = 1'b0;
            end
            answers_due.push_back(r);
        end
    endtask

    // Drive one item and hold it until taken; valid drops only while idling
    task automatic send_item(input fis_in_t it);
        while (!calm && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        table_apply(it);
        @(negedge aclk);
    endtask

    // Result side: random back-pressure, compare against the oldest answer
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result key=%h found=%b",
                         $time, m_data.ranked_key, m_data.found);
                errors++;
            end else begin
                if (m_data !== answers_due[0]) begin
                    $display("%0t: mismatch expected key=%h found=%b, got key=%h found=%b",
                             $time, answers_due[0].ranked_key, answers_due[0].found,
                             m_data.ranked_key, m_data.found);
                    errors++;
                end
                void'(answers_due.pop_front());
            end
        end
    end

    // Directed rows; mark = 1 means the typed answer is checked too
    typedef struct {
        logic             act;
        logic [KEY_W-1:0] k;
        logic [4:0]       rk;
        bit               mark;
        logic [KEY_W-1:0] want_key;
        logic             want_found;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(input logic a, input logic [KEY_W-1:0] k,
                                input logic [4:0] rk, input bit m = 1'b0,
                                input logic [KEY_W-1:0] wk = '0,
                                input logic wf = 1'b0);
        row_t r;
        r.act = a; r.k = k; r.rk = rk; r.mark = m; r.want_key = wk; r.want_found = wf;
        return r;
    endfunction

    fis_in_t pool_keys[8];

    initial begin
        fis_in_t it;
        int n;
        table_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // after reset: every cell empty, rank out of range gives sentinel
        rows.push_back(mk(ACT_GET, '0, 5'd0, 1'b1, SENTINEL_KEY, 1'b1));
        rows.push_back(mk(ACT_GET, '0, 5'd31, 1'b1, SENTINEL_KEY, 1'b0));
        rows.push_back(mk(ACT_GET, '0, 5'd16, 1'b1, SENTINEL_KEY, 1'b0));
        // sentinel key matches the highest empty cell
        rows.push_back(mk(ACT_ADD, SENTINEL_KEY, 5'd0));
        rows.push_back(mk(ACT_ADD, 32'h7FFFFFFF, 5'd0));
        rows.push_back(mk(ACT_ADD, 32'h7FFFFFFF, 5'd0));
        rows.push_back(mk(ACT_ADD, 32'hFFFFFFFF, 5'd0));
        rows.push_back(mk(ACT_ADD, 32'h0, 5'd31));
        rows.push_back(mk(ACT_GET, 32'hFFFFFFFF, 5'd0));
        rows.push_back(mk(ACT_GET, '0, 5'd15));
        rows.push_back(mk(ACT_GET, '0, 5'd1));
        // fill table with distinct keys, then force global floor rises
        for (int i = 0; i < 12; i++) rows.push_back(mk(ACT_ADD, 32'h100 + i, 5'd0));
        for (int i = 0; i < 3; i++) rows.push_back(mk(ACT_ADD, 32'h200 + i, 5'd0));
        rows.push_back(mk(ACT_GET, '0, 5'd2));
        rows.push_back(mk(ACT_GET, '0, 5'd15));

        foreach (rows[i]) begin
            it.action = rows[i].act; it.item_key = rows[i].k; it.rank = rows[i].rk;
            send_item(it);
            if (rows[i].mark && (answers_due[$].ranked_key !== rows[i].want_key ||
                                 answers_due[$].found !== rows[i].want_found)) begin
                $display("%0t: directed row %0d expected key=%h found=%b, model %h %b",
                         $time, i, rows[i].want_key, rows[i].want_found,
                         answers_due[$].ranked_key, answers_due[$].found);
                errors++;
            end
        end

        // random traffic: small key pool for hits, rare wide keys for takeover
        for (int i = 0; i < 8; i++) pool_keys[i].item_key = $urandom;
        pool_keys[0].item_key = SENTINEL_KEY;
        for (n = 0; n < 500; n++) begin
            calm = (n >= 200 && n < 300);
            it.action = ($urandom_range(99) < 25) ? ACT_GET : ACT_ADD;
            it.rank = (it.action == ACT_GET && $urandom_range(3) != 0) ?
                      5'($urandom_range(TABLE_ENTRIES - 1)) : 5'($urandom_range(31));
            if ($urandom_range(9) < 6)
                it.item_key = pool_keys[$urandom_range(7)].item_key;
            else if ($urandom_range(1))
                it.item_key = $urandom_range(40);
            else
                it.item_key = $urandom;
            send_item(it);
        end
        s_valid <= 1'b0;

        calm = 1'b0;
        n = 0;
        while (answers_due.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (40) @(posedge aclk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
